>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for the concurrent checks at the end of the top RTL module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge once the block is out of reset.
`define MVM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// A condition that must never be true once the block is out of reset.
`define MVM_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `MVM_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

>>> rtl/mvm_pkg.sv
// ----------------------------------------------------------------------------
// Matrix-vector multiply package
// Sizes, operation codes and the output scaling function of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mvm_pkg;

    // Store dimensions.
    localparam int MAX_IN  = 64;
    localparam int MAX_OUT = 64;
    localparam int IN_W    = $clog2(MAX_IN);
    localparam int OUT_W   = $clog2(MAX_OUT);
    localparam int W_ADDR_W = IN_W + OUT_W;

    // Field and arithmetic widths.
    localparam int VAL_W  = 16;
    localparam int LEN_W  = 7;
    localparam int PROD_W = 2 * VAL_W;
    localparam int ACC_W  = PROD_W + IN_W + 1;
    localparam int FRAC_W = 8;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_LEN  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LEN = 1'd1;

    // Operation codes carried by a command.
    typedef enum logic [1:0] {
        OP_LOAD_WEIGHT = 2'd0,
        OP_LOAD_VECTOR = 2'd1,
        OP_RUN         = 2'd2
    } t_op;

    // Floor shift by the fraction width, then clamp to the signed 16-bit range.
    function automatic logic [VAL_W-1:0] scale_sat(input logic [ACC_W-1:0] acc);
        logic [ACC_W-FRAC_W-1:0] q;
        logic [ACC_W-FRAC_W-VAL_W:0] top;
        q   = acc[ACC_W-1:FRAC_W];
        top = q[ACC_W-FRAC_W-1:VAL_W-1];
        if ((&top) || !(|top)) begin
            scale_sat = q[VAL_W-1:0];
        end else if (q[ACC_W-FRAC_W-1]) begin
            scale_sat = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            scale_sat = {1'b0, {(VAL_W-1){1'b1}}};
        end
    endfunction

endpackage

>>> rtl/mvm_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mvm_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/matrix_vector_multiply.sv
// ----------------------------------------------------------------------------
// Matrix-vector multiply
// Input vector times transposed weight matrix, signed Q8.8, one shared MAC.
// ----------------------------------------------------------------------------
// Usage:
//   Commands are transferred when i_start is high and o_busy is low. A weight
//   load writes weight[in_index][out_index], a vector load writes
//   vector[in_index]; neither raises o_busy, so loads may follow each other
//   in every cycle. Operation 3 is ignored.
//   A run raises o_busy and walks the stored entries with one multiplier and
//   one accumulator, one product per cycle. Both lengths are capped at 64.
//   The pace is set by the single multiply-accumulate unit and the one read
//   port of the weight memory. Each result is shown for one cycle with
//   o_result_valid high; the final one carries o_last. A run with out_len of
//   zero gives no results. The receiver cannot stall: every strobed result is
//   taken. The user sets the lengths on the configuration channel (index 0
//   in_len, index 1 out_len) only while the block is idle; the block itself
//   does not enforce this. o_cfg_ready is always high.
//   Reset sets both lengths to 64 and empties the pipeline; store contents
//   are undefined until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module matrix_vector_multiply (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Command channel
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  logic [1:0]                           i_operation,
    input  logic [5:0]                           i_in_index,
    input  logic [5:0]                           i_out_index,
    input  logic signed [15:0]                   i_load_value,
    // Result channel
    output logic                                 o_result_valid,
    output logic signed [15:0]                   o_result_value,
    output logic [5:0]                           o_result_index,
    output logic                                 o_last,
    // Configuration channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [mvm_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [mvm_pkg::LEN_W-1:0]            i_cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } t_state;

    // Control and configuration registers.
    t_state                         r_state, n_state;
    logic [mvm_pkg::LEN_W-1:0]      r_in_len;
    logic [mvm_pkg::LEN_W-1:0]      r_out_len;
    logic [mvm_pkg::IN_W-1:0]       r_row, n_row;
    logic [mvm_pkg::OUT_W-1:0]      r_col, n_col;
    logic [mvm_pkg::IN_W-1:0]       r_row_last;
    logic [mvm_pkg::OUT_W-1:0]      r_col_last;
    logic                           r_zero;

    // Pipeline registers: memory read, product, accumulate, output.
    logic                           r_s1_valid, r_s1_first, r_s1_last, r_s1_end;
    logic [mvm_pkg::OUT_W-1:0]      r_s1_col;
    logic                           r_s2_valid, r_s2_first, r_s2_last, r_s2_end;
    logic [mvm_pkg::OUT_W-1:0]      r_s2_col;
    logic signed [mvm_pkg::PROD_W-1:0] r_prod;
    logic [mvm_pkg::ACC_W-1:0]      r_acc, n_acc;
    logic                           r_sum_valid, r_sum_end;
    logic [mvm_pkg::OUT_W-1:0]      r_sum_col;
    logic                           r_out_valid, r_out_last;
    logic [mvm_pkg::VAL_W-1:0]      r_out_value;
    logic [mvm_pkg::OUT_W-1:0]      r_out_index;

    // Command decode and memory ports.
    logic                           accept;
    logic                           run_go;
    logic                           issue;
    logic                           w_we, v_we;
    logic [mvm_pkg::VAL_W-1:0]      w_rdata, v_rdata;
    logic [mvm_pkg::LEN_W-1:0]      n_in_sat, n_out_sat;
    logic                           row_done, col_done;

    assign accept = i_start && (r_state == ST_IDLE);
    assign issue  = (r_state == ST_ISSUE);

    // Decode the transferred command.
    always_comb begin
        w_we   = 1'b0;
        v_we   = 1'b0;
        run_go = 1'b0;
        if (accept) begin
            case (i_operation)
                mvm_pkg::OP_LOAD_WEIGHT: w_we = 1'b1;
                mvm_pkg::OP_LOAD_VECTOR: v_we = 1'b1;
                mvm_pkg::OP_RUN:         run_go = 1'b1;
                default: ;
            endcase
        end
    end

    // Lengths clamped to the store dimensions.
    assign n_in_sat  = (r_in_len > mvm_pkg::LEN_W'(mvm_pkg::MAX_IN)) ?
                       mvm_pkg::LEN_W'(mvm_pkg::MAX_IN) : r_in_len;
    assign n_out_sat = (r_out_len > mvm_pkg::LEN_W'(mvm_pkg::MAX_OUT)) ?
                       mvm_pkg::LEN_W'(mvm_pkg::MAX_OUT) : r_out_len;

    // Weight store, row-major by input index.
    mvm_ram #(
        .DATA_W (mvm_pkg::VAL_W),
        .DEPTH  (mvm_pkg::MAX_IN * mvm_pkg::MAX_OUT)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr ({i_in_index[mvm_pkg::IN_W-1:0], i_out_index[mvm_pkg::OUT_W-1:0]}),
        .i_wdata (i_load_value),
        .i_raddr ({r_row, r_col}),
        .o_rdata (w_rdata)
    );

    // Input vector store.
    mvm_ram #(
        .DATA_W (mvm_pkg::VAL_W),
        .DEPTH  (mvm_pkg::MAX_IN)
    ) u_vector_ram (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (i_in_index[mvm_pkg::IN_W-1:0]),
        .i_wdata (i_load_value),
        .i_raddr (r_row),
        .o_rdata (v_rdata)
    );

    // Sequencer: walk rows within a column, then move to the next column.
    assign row_done = (r_row == r_row_last);
    assign col_done = (r_col == r_col_last);

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_col   = r_col;
        case (r_state)
            ST_IDLE: begin
                n_row = '0;
                n_col = '0;
                if (run_go && (n_out_sat != '0)) begin
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (row_done) begin
                    n_row = '0;
                    if (col_done) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end else begin
                    n_row = r_row + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (r_out_valid && r_out_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Accumulator: a new column starts from its first product.
    assign n_acc = (r_s2_first ? '0 : r_acc) +
                   {{(mvm_pkg::ACC_W-mvm_pkg::PROD_W){r_prod[mvm_pkg::PROD_W-1]}}, r_prod};

    // State, pipeline and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_len    <= mvm_pkg::LEN_W'(mvm_pkg::MAX_IN);
            r_out_len   <= mvm_pkg::LEN_W'(mvm_pkg::MAX_OUT);
            r_row       <= '0;
            r_col       <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_sum_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;

            // Configuration transfer.
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    mvm_pkg::CFG_IN_LEN:  r_in_len  <= i_cfg_data;
                    mvm_pkg::CFG_OUT_LEN: r_out_len <= i_cfg_data;
                    default: ;
                endcase
            end

            // Latch the run bounds; an empty sum runs one zeroed step per column.
            if (run_go) begin
                r_zero     <= (n_in_sat == '0);
                r_row_last <= (n_in_sat == '0) ? '0 : mvm_pkg::IN_W'(n_in_sat - 1'b1);
                r_col_last <= mvm_pkg::OUT_W'(n_out_sat - 1'b1);
            end

            // Stage 1: memory read data arrives.
            r_s1_valid <= issue;
            r_s1_first <= (r_row == '0);
            r_s1_last  <= row_done;
            r_s1_end   <= row_done && col_done;
            r_s1_col   <= r_col;

            // Stage 2: signed product of the two stored values.
            r_s2_valid <= r_s1_valid;
            r_s2_first <= r_s1_first;
            r_s2_last  <= r_s1_last;
            r_s2_end   <= r_s1_end;
            r_s2_col   <= r_s1_col;
            if (r_zero) begin
                r_prod <= '0;
            end else begin
                r_prod <= $signed(v_rdata) * $signed(w_rdata);
            end

            // Stage 3: accumulate; the column sum is complete on its last row.
            if (r_s2_valid) begin
                r_acc <= n_acc;
            end
            r_sum_valid <= r_s2_valid && r_s2_last;
            r_sum_end   <= r_s2_end;
            r_sum_col   <= r_s2_col;

            // Stage 4: scale, saturate and present the result.
            r_out_valid <= r_sum_valid;
            r_out_last  <= r_sum_end;
            r_out_index <= r_sum_col;
            r_out_value <= mvm_pkg::scale_sat(r_acc);
        end
    end

    assign o_busy         = (r_state != ST_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_result_valid = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_result_index = r_out_index;
    assign o_last         = r_out_valid && r_out_last;

    // Checks on the sequencer and the pipeline.
    `MVM_ASSERT(a_result_in_run, i_clk, i_rst_n, o_result_valid |-> o_busy, "result outside a run")
    `MVM_ASSERT(a_last_ends_run, i_clk, i_rst_n, o_last |=> !o_busy, "run did not end after last")
    `MVM_ASSERT_NEVER(a_idle_pipe_empty, i_clk, i_rst_n, !o_busy && (r_s1_valid || r_s2_valid || r_sum_valid || r_out_valid), "idle with work in flight")
    `MVM_ASSERT(a_col_bound, i_clk, i_rst_n, issue |-> (r_col <= r_col_last), "column past bound")

endmodule
